[src/cmft_pkg.sv]
// Shared constants, types and helpers for the cube map texel address block.
`timescale 1ns / 1ps
package cmft_pkg;

   localparam int MAX_FACE_SIZE = 1024;
   localparam int SIZE_W = 11;
   localparam int TEXEL_W = 10;
   localparam int OFFSET_W = 20;
   localparam int DIR_W = 16;
   localparam int PIXEL_X_W = 10;
   localparam int PIXEL_Y_W = 9;
   localparam int FACE_W = 3;
   localparam int QUOT_W = 17;
   localparam int DIV_STEPS = QUOT_W;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_FACE_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FACE_HEIGHT = 1'd1;
   localparam logic [SIZE_W-1:0] FACE_SIZE_RESET = 11'd256;

   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   typedef struct packed {
      logic [FACE_W-1:0]    face;
      logic                 zero;
      logic [PIXEL_X_W-1:0] px;
      logic [PIXEL_Y_W-1:0] py;
   } cmft_side_type;

   // Clamps a programmed face size into the range 1 .. MAX_FACE_SIZE.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      begin
         r = s;
         if (s == '0) begin
            r = SIZE_W'(1);
         end else if (s > SIZE_W'(MAX_FACE_SIZE)) begin
            r = SIZE_W'(MAX_FACE_SIZE);
         end
         return r;
      end
   endfunction

endpackage

[src/cmft_if.sv]
// Channel interfaces for direction requests and texel address responses.
`timescale 1ns / 1ps
interface cmft_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cmft_pkg::DIR_W-1:0]     dir_x;
   logic signed [cmft_pkg::DIR_W-1:0]     dir_y;
   logic signed [cmft_pkg::DIR_W-1:0]     dir_z;
   logic        [cmft_pkg::PIXEL_X_W-1:0] pixel_x;
   logic        [cmft_pkg::PIXEL_Y_W-1:0] pixel_y;

   modport source (output valid, dir_x, dir_y, dir_z, pixel_x, pixel_y, input ready);
   modport sink (input valid, dir_x, dir_y, dir_z, pixel_x, pixel_y, output ready);
endinterface

interface cmft_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [cmft_pkg::FACE_W-1:0]           face_index;
   logic [cmft_pkg::TEXEL_W-1:0]          texel_x;
   logic [cmft_pkg::TEXEL_W-1:0]          texel_y;
   logic [cmft_pkg::OFFSET_W-1:0]         texel_offset;
   logic                                  zero_vector;
   logic [cmft_pkg::PIXEL_X_W-1:0]        out_pixel_x;
   logic [cmft_pkg::PIXEL_Y_W-1:0]        out_pixel_y;

   modport source (output valid, face_index, texel_x, texel_y, texel_offset,
                   zero_vector, out_pixel_x, out_pixel_y, input ready);
   modport sink (input valid, face_index, texel_x, texel_y, texel_offset,
                 zero_vector, out_pixel_x, out_pixel_y, output ready);
endinterface

[src/cmft_div.sv]
// Pipelined restoring divider: quotient of (numer << 15) / denom, one bit a stage.
`timescale 1ns / 1ps
module cmft_div (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [cmft_pkg::QUOT_W-1:0]   numer,
   input  logic [cmft_pkg::DIR_W-1:0]    denom,
   output logic [cmft_pkg::QUOT_W-1:0]   quot
);

   localparam int N = cmft_pkg::DIV_STEPS;
   localparam int DW = cmft_pkg::DIR_W;
   localparam int QW = cmft_pkg::QUOT_W;

   logic [DW-1:0] rem_ff [N];
   logic [DW-1:0] den_ff [N];
   logic [QW-1:0] quo_ff [N];
   logic [1:0]    lo_ff  [N];

   // The numerator's two low bits feed the first two steps; the rest are zero.
   // The starting remainder numer >> 2 is below denom, so 17 steps suffice.
   for (genvar g = 0; g < N; g++) begin : g_step
      logic [DW-1:0]   rem_cur;
      logic [DW-1:0]   den_cur;
      logic [QW-1:0]   quo_cur;
      logic [1:0]      lo_cur;
      logic [DW+1:0]   trial;

      if (g == 0) begin : g_first
         assign rem_cur = {1'b0, numer[QW-1:2]};
         assign den_cur = denom;
         assign quo_cur = '0;
         assign lo_cur  = numer[1:0];
      end else begin : g_rest
         assign rem_cur = rem_ff[g-1];
         assign den_cur = den_ff[g-1];
         assign quo_cur = quo_ff[g-1];
         assign lo_cur  = lo_ff[g-1];
      end

      assign trial = {1'b0, rem_cur, lo_cur[1]} - {2'b00, den_cur};

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[g] <= den_cur;
            lo_ff[g]  <= {lo_cur[0], 1'b0};
            if (!trial[DW+1]) begin
               rem_ff[g] <= trial[DW-1:0];
               quo_ff[g] <= {quo_cur[QW-2:0], 1'b1};
            end else begin
               rem_ff[g] <= {rem_cur[DW-2:0], lo_cur[1]};
               quo_ff[g] <= {quo_cur[QW-2:0], 1'b0};
            end
         end
      end
   end

   assign quot = quo_ff[N-1];

endmodule

[src/cube_map_face_texel_address.sv]
// Cube map face selection and texel addressing pipeline, top level.
// Requests pass stage 1, the divider, the multiply stage and the output stage.
// Throughput: one transaction per cycle; the 17-stage divider sets the depth.
// The whole pipeline holds when the output register is full and not taken.
// Reset (synchronous, active high) clears all valid bits and sets both face
// sizes to 256; the block takes requests in the first cycle after reset.
`timescale 1ns / 1ps
module cube_map_face_texel_address (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [cmft_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cmft_pkg::SIZE_W-1:0]           csr_write_data,
   cmft_req_if.sink                              req,
   cmft_rsp_if.source                            rsp
);

   localparam int N = cmft_pkg::DIV_STEPS;
   localparam int DW = cmft_pkg::DIR_W;
   localparam int SW = cmft_pkg::SIZE_W;
   localparam int TW = cmft_pkg::TEXEL_W;
   localparam int QW = cmft_pkg::QUOT_W;

   // Configuration registers.
   logic [SW-1:0] face_width_ff, face_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_width_ff  <= cmft_pkg::FACE_SIZE_RESET;
         face_height_ff <= cmft_pkg::FACE_SIZE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cmft_pkg::REG_FACE_WIDTH:  face_width_ff  <= csr_write_data;
            cmft_pkg::REG_FACE_HEIGHT: face_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [SW-1:0] eff_w, eff_h;
   assign eff_w = cmft_pkg::eff_size(face_width_ff);
   assign eff_h = cmft_pkg::eff_size(face_height_ff);

   // Every stage moves together; it moves whenever the output register is
   // empty or its transaction is being taken.
   logic out_valid_ff;
   logic advance;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // Stage 1: major axis, face and the face's signed minor components.
   logic signed [DW:0] xe, ye, ze;
   logic [DW-1:0]      ax, ay, az;
   logic [DW-1:0]      m_in;
   logic signed [DW:0] su_in, sv_in;
   logic [cmft_pkg::FACE_W-1:0] face_in;

   assign xe = {req.dir_x[DW-1], req.dir_x};
   assign ye = {req.dir_y[DW-1], req.dir_y};
   assign ze = {req.dir_z[DW-1], req.dir_z};
   assign ax = xe[DW] ? DW'(-xe) : DW'(xe);
   assign ay = ye[DW] ? DW'(-ye) : DW'(ye);
   assign az = ze[DW] ? DW'(-ze) : DW'(ze);

   // Ties go to x, then y; the positive face needs a strictly positive component.
   always_comb begin
      if (ax >= ay && ax >= az) begin
         m_in  = ax;
         sv_in = -ye;
         if (!xe[DW] && xe != '0) begin
            face_in = cmft_pkg::FACE_POS_X;
            su_in   = -ze;
         end else begin
            face_in = cmft_pkg::FACE_NEG_X;
            su_in   = ze;
         end
      end else if (ay >= az) begin
         m_in  = ay;
         su_in = xe;
         if (!ye[DW] && ye != '0) begin
            face_in = cmft_pkg::FACE_POS_Y;
            sv_in   = ze;
         end else begin
            face_in = cmft_pkg::FACE_NEG_Y;
            sv_in   = -ze;
         end
      end else begin
         m_in  = az;
         sv_in = -ye;
         if (!ze[DW] && ze != '0) begin
            face_in = cmft_pkg::FACE_POS_Z;
            su_in   = xe;
         end else begin
            face_in = cmft_pkg::FACE_NEG_Z;
            su_in   = -xe;
         end
      end
   end

   logic                    s1_valid_ff;
   cmft_pkg::cmft_side_type s1_side_ff;
   logic [DW-1:0]           s1_m_ff;
   logic signed [DW:0]      s1_su_ff, s1_sv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff.face <= face_in;
         s1_side_ff.zero <= (ax == '0) && (ay == '0) && (az == '0);
         s1_side_ff.px   <= req.pixel_x;
         s1_side_ff.py   <= req.pixel_y;
         s1_m_ff         <= m_in;
         s1_su_ff        <= su_in;
         s1_sv_ff        <= sv_in;
      end
   end

   // Divider inputs: the offset component s + m lies in 0 .. 2m. A zero vector
   // divides by one so the divider never sees a zero divisor.
   logic signed [DW+1:0] nu_wide, nv_wide;
   logic [QW-1:0]        numer_u, numer_v;
   logic [DW-1:0]        denom;

   assign nu_wide = {s1_su_ff[DW], s1_su_ff} + $signed({2'b00, s1_m_ff});
   assign nv_wide = {s1_sv_ff[DW], s1_sv_ff} + $signed({2'b00, s1_m_ff});
   assign numer_u = s1_side_ff.zero ? '0 : nu_wide[QW-1:0];
   assign numer_v = s1_side_ff.zero ? '0 : nv_wide[QW-1:0];
   assign denom   = s1_side_ff.zero ? DW'(1) : s1_m_ff;

   logic [QW-1:0] t_u, t_v;

   cmft_div u_div_u (
      .clock   (clock),
      .advance (advance),
      .numer   (numer_u),
      .denom   (denom),
      .quot    (t_u)
   );

   cmft_div u_div_v (
      .clock   (clock),
      .advance (advance),
      .numer   (numer_v),
      .denom   (denom),
      .quot    (t_v)
   );

   // Sideband travels beside the divider, one entry per divider step.
   logic                    dv_valid_ff [N];
   cmft_pkg::cmft_side_type dv_side_ff  [N];

   for (genvar g = 0; g < N; g++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[g] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[g] <= (g == 0) ? s1_valid_ff : dv_valid_ff[(g == 0) ? 0 : g-1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            dv_side_ff[g] <= (g == 0) ? s1_side_ff : dv_side_ff[(g == 0) ? 0 : g-1];
         end
      end
   end

   // Multiply stage: scale the Q1.16 fraction by size minus one and drop the
   // fraction bits. The fraction never exceeds one, so no clamp is needed.
   logic [SW-1:0]    wm1, hm1;
   logic [QW+SW-1:0] prod_x, prod_y;

   assign wm1    = eff_w - SW'(1);
   assign hm1    = eff_h - SW'(1);
   assign prod_x = {{SW{1'b0}}, t_u} * {{QW{1'b0}}, wm1};
   assign prod_y = {{SW{1'b0}}, t_v} * {{QW{1'b0}}, hm1};

   logic                    s3_valid_ff;
   cmft_pkg::cmft_side_type s3_side_ff;
   logic [TW-1:0]           s3_tx_ff, s3_ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= dv_valid_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_side_ff <= dv_side_ff[N-1];
         s3_tx_ff   <= dv_side_ff[N-1].zero ? '0 : prod_x[16+TW-1:16];
         s3_ty_ff   <= dv_side_ff[N-1].zero ? '0 : prod_y[16+TW-1:16];
      end
   end

   // Output stage: fetch offset row * width + column, held in the output register.
   logic [TW+SW-1:0] off_full;
   assign off_full = {{SW{1'b0}}, s3_ty_ff} * {{TW{1'b0}}, eff_w}
                   + {{SW{1'b0}}, s3_tx_ff};

   logic                           out_zero_ff;
   logic [cmft_pkg::FACE_W-1:0]    out_face_ff;
   logic [TW-1:0]                  out_tx_ff, out_ty_ff;
   logic [cmft_pkg::OFFSET_W-1:0]  out_off_ff;
   logic [cmft_pkg::PIXEL_X_W-1:0] out_px_ff;
   logic [cmft_pkg::PIXEL_Y_W-1:0] out_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_face_ff <= s3_side_ff.face;
         out_zero_ff <= s3_side_ff.zero;
         out_px_ff   <= s3_side_ff.px;
         out_py_ff   <= s3_side_ff.py;
         out_tx_ff   <= s3_tx_ff;
         out_ty_ff   <= s3_ty_ff;
         out_off_ff  <= off_full[cmft_pkg::OFFSET_W-1:0];
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.face_index   = out_face_ff;
   assign rsp.texel_x      = out_tx_ff;
   assign rsp.texel_y      = out_ty_ff;
   assign rsp.texel_offset = out_off_ff;
   assign rsp.zero_vector  = out_zero_ff;
   assign rsp.out_pixel_x  = out_px_ff;
   assign rsp.out_pixel_y  = out_py_ff;

endmodule

[src/cmft_checker.sv]
// Port-level checks on the cube map texel address block, bound to the top level.
`timescale 1ns / 1ps
module cmft_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [cmft_pkg::FACE_W-1:0]          face_index,
   input logic [cmft_pkg::TEXEL_W-1:0]         texel_x,
   input logic [cmft_pkg::TEXEL_W-1:0]         texel_y,
   input logic [cmft_pkg::OFFSET_W-1:0]        texel_offset,
   input logic                                 zero_vector
);

   // A stalled response keeps its face and offset.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(face_index) && $stable(texel_offset))
      else $error("stalled response changed");

   // A zero direction yields the negative x face and texel zero.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zero_vector |-> face_index == cmft_pkg::FACE_NEG_X
         && texel_x == '0 && texel_y == '0 && texel_offset == '0)
      else $error("zero direction gave a nonzero texel");

   // Only the six cube faces are ever reported.
   a_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> face_index <= cmft_pkg::FACE_NEG_Z)
      else $error("face index out of range");

   // The offset is never below the column it contains.
   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> texel_offset >= {{(cmft_pkg::OFFSET_W - cmft_pkg::TEXEL_W){1'b0}}, texel_x})
      else $error("offset below texel column");

endmodule

bind cube_map_face_texel_address cmft_checker u_cmft_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .face_index   (rsp.face_index),
   .texel_x      (rsp.texel_x),
   .texel_y      (rsp.texel_y),
   .texel_offset (rsp.texel_offset),
   .zero_vector  (rsp.zero_vector)
);

[dv/tb_cube_map_face_texel_address.sv]
// Self-checking testbench for the cube map face selection and texel address block.
`timescale 1ns / 1ps
module tb_cube_map_face_texel_address;

   // Field widths taken from the shared package.
   localparam int FACE_W = cmft_pkg::FACE_W;
   localparam int TEXEL_W = cmft_pkg::TEXEL_W;
   localparam int OFFSET_W = cmft_pkg::OFFSET_W;
   localparam int DIR_W = cmft_pkg::DIR_W;
   localparam int PIXEL_X_W = cmft_pkg::PIXEL_X_W;
   localparam int PIXEL_Y_W = cmft_pkg::PIXEL_Y_W;
   localparam int SIZE_W = cmft_pkg::SIZE_W;
   localparam int CSR_INDEX_W = cmft_pkg::CSR_INDEX_W;

   // The block is pipelined, so the drain at the end and the quiet time before a
   // size change wait DRAIN_CYCLES more once the last response is back.
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1250;

   typedef struct packed {
      logic [FACE_W-1:0]    face;
      logic [TEXEL_W-1:0]   tx;
      logic [TEXEL_W-1:0]   ty;
      logic [OFFSET_W-1:0]  offset;
      logic                 zero;
      logic [PIXEL_X_W-1:0] px;
      logic [PIXEL_Y_W-1:0] py;
   } texel_address_type;

   typedef struct packed {
      logic [DIR_W-1:0]     dx;
      logic [DIR_W-1:0]     dy;
      logic [DIR_W-1:0]     dz;
      logic [PIXEL_X_W-1:0] px;
      logic [PIXEL_Y_W-1:0] py;
   } direction_type;

   // One row of the directed table; when has_face is set the face index and
   // the zero flag are typed in and checked against the predictor as well.
   typedef struct {
      direction_type     dir;
      bit                has_face;
      logic [FACE_W-1:0] face;
      logic              zero;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [SIZE_W-1:0] csr_write_data;

   cmft_req_if req ();
   cmft_rsp_if rsp ();

   cube_map_face_texel_address uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req.sink),
      .rsp              (rsp.source)
   );

   // The predictor's own copy of the two face size registers.
   logic [SIZE_W-1:0] model_width;
   logic [SIZE_W-1:0] model_height;

   texel_address_type pending_addresses[$];
   int errors;
   int cycles;
   int send_idle_pct;
   int take_idle_pct;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The cycle counter guards against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("cube_map_face_texel_address regression: fail");
         $finish;
      end
   end

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
      if (s == '0) return SIZE_W'(1);
      if (s > SIZE_W'(cmft_pkg::MAX_FACE_SIZE)) return SIZE_W'(cmft_pkg::MAX_FACE_SIZE);
      return s;
   endfunction

   // Maps a signed minor component s in [-m, m] to a texel index on a face side.
   function automatic logic [TEXEL_W-1:0] minor_to_texel(input longint s, input longint m,
                                                         input longint size);
      longint n;
      longint frac;
      longint idx;
      n = s + m;
      if (n < 0) n = 0;
      if (n > 2 * m) n = 2 * m;
      frac = (n << 15) / m;
      if (frac > 65536) frac = 65536;
      idx = (frac * (size - 1)) >> 16;
      if (idx > size - 1) idx = size - 1;
      return idx[TEXEL_W-1:0];
   endfunction

   function automatic texel_address_type predict_texel_address(input direction_type d);
      texel_address_type r;
      longint x, y, z, ax, ay, az, m, su, sv, w, h, off;
      x = longint'($signed(d.dx));
      y = longint'($signed(d.dy));
      z = longint'($signed(d.dz));
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      w = longint'(clamp_size(model_width));
      h = longint'(clamp_size(model_height));
      r = '0;
      if (ax >= ay && ax >= az) begin
         m = ax;
         sv = -y;
         if (x > 0) begin
            r.face = cmft_pkg::FACE_POS_X;
            su = -z;
         end else begin
            r.face = cmft_pkg::FACE_NEG_X;
            su = z;
         end
      end else if (ay >= az) begin
         m = ay;
         su = x;
         if (y > 0) begin
            r.face = cmft_pkg::FACE_POS_Y;
            sv = z;
         end else begin
            r.face = cmft_pkg::FACE_NEG_Y;
            sv = -z;
         end
      end else begin
         m = az;
         sv = -y;
         if (z > 0) begin
            r.face = cmft_pkg::FACE_POS_Z;
            su = x;
         end else begin
            r.face = cmft_pkg::FACE_NEG_Z;
            su = -x;
         end
      end
      r.zero = (m == 0);
      if (m != 0) begin
         r.tx = minor_to_texel(su, m, w);
         r.ty = minor_to_texel(sv, m, h);
         off = longint'(r.ty) * w + longint'(r.tx);
         r.offset = off[OFFSET_W-1:0];
      end
      r.px = d.px;
      r.py = d.py;
      return r;
   endfunction

   // Response side: random back-pressure and a field-by-field comparison.
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= take_idle_pct);
   end

   always @(posedge clock) begin
      texel_address_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_addresses.size() == 0) begin
            $error("unexpected transaction: face_index %0d", rsp.face_index);
            errors++;
         end else begin
            want = pending_addresses.pop_front();
            if (rsp.face_index !== want.face) begin
               $error("face_index: expected %0d, got %0d", want.face, rsp.face_index);
               errors++;
            end
            if (rsp.texel_x !== want.tx) begin
               $error("texel_x: expected %0d, got %0d", want.tx, rsp.texel_x);
               errors++;
            end
            if (rsp.texel_y !== want.ty) begin
               $error("texel_y: expected %0d, got %0d", want.ty, rsp.texel_y);
               errors++;
            end
            if (rsp.texel_offset !== want.offset) begin
               $error("texel_offset: expected %0d, got %0d", want.offset, rsp.texel_offset);
               errors++;
            end
            if (rsp.zero_vector !== want.zero) begin
               $error("zero_vector: expected %0d, got %0d", want.zero, rsp.zero_vector);
               errors++;
            end
            if (rsp.out_pixel_x !== want.px) begin
               $error("out_pixel_x: expected %0d, got %0d", want.px, rsp.out_pixel_x);
               errors++;
            end
            if (rsp.out_pixel_y !== want.py) begin
               $error("out_pixel_y: expected %0d, got %0d", want.py, rsp.out_pixel_y);
               errors++;
            end
         end
      end
   end

   // Presents one direction, with random idle cycles first, and waits for
   // acceptance. The expectation is queued at the accepting edge.
   task automatic send_direction(input direction_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid   <= 1'b1;
      req.dir_x   <= d.dx;
      req.dir_y   <= d.dy;
      req.dir_z   <= d.dz;
      req.pixel_x <= d.px;
      req.pixel_y <= d.py;
      do @(posedge clock); while (!req.ready);
      pending_addresses.push_back(predict_texel_address(d));
      @(negedge clock);
   endtask

   // Lowers valid and waits until every response has come back, plus margin.
   task automatic drain_pipeline();
      req.valid <= 1'b0;
      while (pending_addresses.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Size changes only while the pipeline is empty; the write enable is lowered
   // after each write so that writes never run together.
   task automatic write_face_size(input logic [CSR_INDEX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == cmft_pkg::REG_FACE_WIDTH) model_width = value;
      else model_height = value;
      @(negedge clock);
   endtask

   function automatic logic [DIR_W-1:0] random_component();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return DIR_W'($signed($urandom_range(64)) - 32);
         default: return DIR_W'($urandom);
      endcase
   endfunction

   // Mostly well-formed directions; ties between components are forced often.
   function automatic direction_type random_direction();
      direction_type d;
      d.dx = random_component();
      d.dy = random_component();
      d.dz = random_component();
      case ($urandom_range(5))
         0: d.dy = $urandom_range(1) ? d.dx : -d.dx;
         1: d.dz = $urandom_range(1) ? d.dy : -d.dy;
         2: d.dz = $urandom_range(1) ? d.dx : -d.dx;
         default: ;
      endcase
      d.px = $urandom_range(3) == 0 ? PIXEL_X_W'($urandom) : PIXEL_X_W'($urandom_range(639));
      d.py = $urandom_range(3) == 0 ? PIXEL_Y_W'($urandom) : PIXEL_Y_W'($urandom_range(479));
      return d;
   endfunction

   directed_row_type directed_rows[$];
   logic [SIZE_W-1:0] size_plan[8] = '{11'd256, 11'd1, 11'd1024, 11'd0,
                                       11'd2047, 11'd1025, 11'd2, 11'd640};

   initial begin
      direction_type d;
      int phase;
      errors = 0;
      cycles = 0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = cmft_pkg::REG_FACE_WIDTH;
      csr_write_data = '0;
      req.valid = 1'b0;
      req.dir_x = '0;
      req.dir_y = '0;
      req.dir_z = '0;
      req.pixel_x = '0;
      req.pixel_y = '0;
      rsp.ready = 1'b0;
      model_width = cmft_pkg::FACE_SIZE_RESET;
      model_height = cmft_pkg::FACE_SIZE_RESET;

      // Zero vector, each face, the most negative value, ties and full scale.
      directed_rows = '{
         '{'{16'h0000, 16'h0000, 16'h0000, 10'd0, 9'd0}, 1, cmft_pkg::FACE_NEG_X, 1'b1},
         '{'{16'h7FFF, 16'h0000, 16'h0000, 10'd639, 9'd479}, 1, cmft_pkg::FACE_POS_X, 1'b0},
         '{'{16'h8000, 16'h0000, 16'h0000, 10'd1023, 9'd511}, 1, cmft_pkg::FACE_NEG_X, 1'b0},
         '{'{16'h0000, 16'h7FFF, 16'h0000, 10'd1, 9'd1}, 1, cmft_pkg::FACE_POS_Y, 1'b0},
         '{'{16'h0000, 16'h8000, 16'h0000, 10'd2, 9'd2}, 1, cmft_pkg::FACE_NEG_Y, 1'b0},
         '{'{16'h0000, 16'h0000, 16'h7FFF, 10'd3, 9'd3}, 1, cmft_pkg::FACE_POS_Z, 1'b0},
         '{'{16'h0000, 16'h0000, 16'h8000, 10'd4, 9'd4}, 1, cmft_pkg::FACE_NEG_Z, 1'b0},
         '{'{16'h4000, 16'h4000, 16'h4000, 10'd5, 9'd5}, 1, cmft_pkg::FACE_POS_X, 1'b0},
         '{'{16'hC000, 16'h4000, 16'h4000, 10'd6, 9'd6}, 1, cmft_pkg::FACE_NEG_X, 1'b0},
         '{'{16'h0100, 16'h4000, 16'h4000, 10'd7, 9'd7}, 1, cmft_pkg::FACE_POS_Y, 1'b0},
         '{'{16'h0100, 16'hC000, 16'h4000, 10'd8, 9'd8}, 1, cmft_pkg::FACE_NEG_Y, 1'b0},
         '{'{16'h8000, 16'h7FFF, 16'h8000, 10'd9, 9'd9}, 0, '0, 1'b0},
         '{'{16'h7FFF, 16'h8000, 16'h7FFF, 10'd10, 9'd10}, 0, '0, 1'b0},
         '{'{16'h0001, 16'hFFFF, 16'h0000, 10'd11, 9'd11}, 0, '0, 1'b0},
         '{'{16'h1234, 16'hEDCC, 16'h0F00, 10'd700, 9'd500}, 0, '0, 1'b0},
         '{'{16'h0000, 16'h0001, 16'h0000, 10'd12, 9'd12}, 1, cmft_pkg::FACE_POS_Y, 1'b0},
         '{'{16'h0000, 16'h0000, 16'hFFFF, 10'd13, 9'd13}, 1, cmft_pkg::FACE_NEG_Z, 1'b0},
         '{'{16'h5555, 16'hAAAA, 16'h5555, 10'd682, 9'd341}, 0, '0, 1'b0}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].has_face) begin
            texel_address_type p;
            p = predict_texel_address(directed_rows[i].dir);
            if (p.face !== directed_rows[i].face) begin
               $error("directed row %0d: face_index expected %0d, predicted %0d",
                      i, directed_rows[i].face, p.face);
               errors++;
            end
            if (p.zero !== directed_rows[i].zero) begin
               $error("directed row %0d: zero_vector expected %0d, predicted %0d",
                      i, directed_rows[i].zero, p.zero);
               errors++;
            end
            if (p.zero && (p.tx != 0 || p.ty != 0 || p.offset != 0)) begin
               $error("directed row %0d: texel_offset expected 0, predicted %0d", i, p.offset);
               errors++;
            end
         end
         send_direction(directed_rows[i].dir);
      end
      drain_pipeline();

      // Random phases, each under its own pair of face sizes and one of three idle mixes.
      for (phase = 0; phase < 8; phase++) begin
         write_face_size(cmft_pkg::REG_FACE_WIDTH, size_plan[phase]);
         write_face_size(cmft_pkg::REG_FACE_HEIGHT, size_plan[(phase + 3) % 8]);
         send_idle_pct = phase < 3 ? 19 : (phase < 6 ? 76 : 0);
         take_idle_pct = phase < 3 ? 76 : (phase < 6 ? 19 : 0);
         for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
            d = random_direction();
            send_direction(d);
            // Once in each phase the sender waits until the pipeline is empty.
            if (n == 40) begin
               req.valid <= 1'b0;
               while (pending_addresses.size() != 0) @(negedge clock);
            end
         end
         drain_pipeline();
      end

      if (errors == 0) begin
         $display("cube_map_face_texel_address regression: pass");
      end else begin
         $display("cube_map_face_texel_address regression: fail");
      end
      $finish;
   end

endmodule
